// ----- sv/char_lcd_write_sequencer_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD write sequencer
// Implication and never-true checks, empty when synthesised.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_WRITE_SEQUENCER_CORE_ASSERT_SVH
`define CHAR_LCD_WRITE_SEQUENCER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define CLWS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

`define CLWS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error(msg);

`else

`define CLWS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`define CLWS_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ----- sv/clws_pkg.sv -----
// ----------------------------------------------------------------------------
// clws_pkg
// Types, constants and the init command table of the LCD write sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clws_pkg;

  localparam int MAX_DIGITS = 5;
  localparam int DIG_IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int INIT_LEN   = 6;
  localparam int MAX_STEPS  = (2 * MAX_DIGITS > INIT_LEN) ? 2 * MAX_DIGITS : INIT_LEN;
  localparam int STEP_W     = $clog2(MAX_STEPS);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [7:0] LCD_CMD_FUNC_SET = 8'h38;
  localparam logic [7:0] LCD_CMD_DISP_ON  = 8'h0C;
  localparam logic [7:0] LCD_CMD_ENTRY    = 8'h06;
  localparam logic [7:0] LCD_CMD_CLEAR    = 8'h01;
  localparam logic [7:0] LCD_ADDR_ROW1    = 8'h80;
  localparam logic [7:0] LCD_ADDR_ROW2    = 8'hC0;
  localparam logic [7:0] ASCII_ZERO       = 8'd48;
  localparam logic [1:0] ROW_FIRST        = 2'd1;

  // floor(v / 10) == (v * RECIP_10) >> RECIP_SHIFT for every 16-bit v
  localparam logic [15:0] RECIP_10    = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  typedef enum logic [1:0] {
    FUNC_INIT  = 2'd0,
    FUNC_CHAR  = 2'd1,
    FUNC_DIGIT = 2'd2,
    FUNC_NUM   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    JOB_INIT,
    JOB_PAIR,
    JOB_NUM
  } job_kind_e;

  typedef enum logic {
    FS_IDLE,
    FS_CONV
  } front_state_e;

  typedef enum logic {
    BS_IDLE,
    BS_RUN
  } back_state_e;

  typedef struct packed {
    job_kind_e                        kind;
    logic [7:0]                       addr;
    logic [7:0]                       data;
    logic [MAX_DIGITS-1:0][3:0]       digits;
    logic [CNT_W-1:0]                 count;
  } job_t;

  function automatic logic [7:0] init_cmd(input logic [STEP_W-1:0] step);
    logic [7:0] cmd;
    cmd = LCD_CMD_FUNC_SET;
    case (step)
      STEP_W'(3): cmd = LCD_CMD_DISP_ON;
      STEP_W'(4): cmd = LCD_CMD_ENTRY;
      STEP_W'(5): cmd = LCD_CMD_CLEAR;
      default:    cmd = LCD_CMD_FUNC_SET;
    endcase
    return cmd;
  endfunction

endpackage

// ----- sv/char_lcd_write_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_core
// Turns display requests into character LCD command and data writes.
// ----------------------------------------------------------------------------
// Each request yields its writes in order, one per cycle while the output is
// not stalled, with last set on the final one. Init gives six writes,
// character and digit two, a number two per shown digit. The write sequencer
// loads each job from a two-entry queue in its idle state before it steps
// through the job's writes. The front end takes a new request while the
// sequencer is busy, unless a job waits on a full queue; a number stalls it
// while its five decimal digits are found in turn through a reciprocal
// multiply by one tenth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module char_lcd_write_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [3:0]  col_i,
  input  logic [1:0]  row_i,
  input  logic [15:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_data_o,
  output logic [7:0]  bus_byte_o,
  output logic        last_o
);
  import clws_pkg::*;

  `include "char_lcd_write_sequencer_core_assert.svh"

  logic push, full, pop, empty;
  job_t push_job, head_job;

  clws_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .col_i      (col_i),
    .row_i      (row_i),
    .value_i    (value_i),
    .push_o     (push),
    .push_job_o (push_job),
    .full_i     (full)
  );

  clws_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head_job)
  );

  clws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_data_o   (is_data_o),
    .bus_byte_o  (bus_byte_o),
    .last_o      (last_o)
  );

  `CLWS_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop && empty, "pop from empty queue")
  `CLWS_ASSERT_IMP(a_push_full, clk_i, rst_ni, push && full, in_stall_o, "accept while queue full")
  `CLWS_ASSERT_IMP(a_cmd_last, clk_i, rst_ni, out_valid_o && last_o && !is_data_o, bus_byte_o == LCD_CMD_CLEAR, "final command write is not clear")

endmodule

// ----- sv/clws_front.sv -----
// ----------------------------------------------------------------------------
// clws_front
// Accepts requests, classifies them and splits numbers into decimal digits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clws_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     func_i,
  input  logic [3:0]     col_i,
  input  logic [1:0]     row_i,
  input  logic [15:0]    value_i,
  output logic           push_o,
  output clws_pkg::job_t push_job_o,
  input  logic           full_i
);
  import clws_pkg::*;

  front_state_e         state_q, state_d;
  logic                 job_valid_q, job_valid_d;
  job_t                 job_q, job_d;
  logic [15:0]          rem_q, rem_d;
  logic [DIG_IDX_W-1:0] cnt_q, cnt_d;

  logic                 in_accept;
  logic [31:0]          prod;
  logic [15:0]          quot;
  logic [15:0]          times10;
  logic [3:0]           dig;
  logic [7:0]           base;

  assign in_stall_o = (state_q == FS_CONV) || (job_valid_q && full_i);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign push_o     = job_valid_q;
  assign push_job_o = job_q;

  assign prod    = 32'(rem_q) * 32'(RECIP_10);
  assign quot    = 16'(prod[31:RECIP_SHIFT]);
  assign times10 = 16'({quot, 3'b000}) + 16'({quot, 1'b0});
  assign dig     = 4'(rem_q - times10);
  assign base    = (row_i == ROW_FIRST) ? LCD_ADDR_ROW1 : LCD_ADDR_ROW2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FS_IDLE;
      job_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      job_valid_q <= job_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    rem_q <= rem_d;
  end

  always_comb begin
    state_d     = state_q;
    job_valid_d = job_valid_q && full_i;
    job_d       = job_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    unique case (state_q)
      FS_IDLE: begin
        if (in_accept) begin
          job_d.addr  = 8'(base + 8'(col_i));
          job_d.data  = value_i[7:0];
          job_d.count = CNT_W'(1);
          unique case (func_e'(func_i))
            FUNC_INIT: begin
              job_d.kind  = JOB_INIT;
              job_valid_d = 1'b1;
            end
            FUNC_CHAR: begin
              job_d.kind  = JOB_PAIR;
              job_valid_d = 1'b1;
            end
            FUNC_DIGIT: begin
              job_d.kind  = JOB_PAIR;
              job_d.data  = 8'(value_i[7:0] + ASCII_ZERO);
              job_valid_d = 1'b1;
            end
            FUNC_NUM: begin
              job_d.kind = JOB_NUM;
              rem_d      = value_i;
              cnt_d      = '0;
              state_d    = FS_CONV;
            end
            default: begin
              job_d.kind = JOB_INIT;
            end
          endcase
        end
      end
      FS_CONV: begin
        job_d.digits[cnt_q] = dig;
        rem_d               = quot;
        if (dig != 4'd0) begin
          job_d.count = CNT_W'(cnt_q) + CNT_W'(1);
        end
        if (cnt_q == DIG_IDX_W'(MAX_DIGITS - 1)) begin
          state_d     = FS_IDLE;
          job_valid_d = 1'b1;
        end else begin
          cnt_d = cnt_q + DIG_IDX_W'(1);
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

endmodule

// ----- sv/clws_queue.sv -----
// ----------------------------------------------------------------------------
// clws_queue
// Short job queue between the request front end and the write sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clws_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  clws_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output clws_pkg::job_t head_o
);
  import clws_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ----- sv/clws_back.sv -----
// ----------------------------------------------------------------------------
// clws_back
// Steps through the bus writes of one job into a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clws_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  clws_pkg::job_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           is_data_o,
  output logic [7:0]     bus_byte_o,
  output logic           last_o
);
  import clws_pkg::*;

  back_state_e       state_q, state_d;
  job_t              job_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              is_data_q;
  logic [7:0]        byte_q;
  logic              last_q;

  logic              produce;
  logic              wr_is_data;
  logic [7:0]        wr_byte;
  logic              wr_last;
  logic [STEP_W-2:0] pos;
  logic [CNT_W-1:0]  dig_sel;
  logic [STEP_W-1:0] num_last_step;

  assign pop_o       = (state_q == BS_IDLE) && !empty_i;
  assign produce     = (state_q == BS_RUN) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign is_data_o   = is_data_q;
  assign bus_byte_o  = byte_q;
  assign last_o      = last_q;

  assign pos           = step_q[STEP_W-1:1];
  assign dig_sel       = job_q.count - CNT_W'(1) - CNT_W'(pos);
  assign num_last_step = STEP_W'({job_q.count, 1'b0}) - STEP_W'(1);

  always_comb begin
    wr_is_data = step_q[0];
    wr_byte    = job_q.addr;
    wr_last    = 1'b0;
    unique case (job_q.kind)
      JOB_INIT: begin
        wr_is_data = 1'b0;
        wr_byte    = init_cmd(step_q);
        wr_last    = (step_q == STEP_W'(INIT_LEN - 1));
      end
      JOB_PAIR: begin
        wr_byte = step_q[0] ? job_q.data : job_q.addr;
        wr_last = step_q[0];
      end
      JOB_NUM: begin
        wr_byte = step_q[0]
                ? 8'(8'(job_q.digits[dig_sel[DIG_IDX_W-1:0]]) + ASCII_ZERO)
                : 8'(job_q.addr + 8'(pos));
        wr_last = (step_q == num_last_step);
      end
      default: wr_last = 1'b1;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      BS_IDLE: begin
        if (!empty_i) begin
          state_d = BS_RUN;
          step_d  = '0;
        end
      end
      BS_RUN: begin
        if (produce) begin
          out_valid_d = 1'b1;
          step_d      = step_q + STEP_W'(1);
          if (wr_last) begin
            state_d = BS_IDLE;
          end
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i;
    end
    if (produce) begin
      is_data_q <= wr_is_data;
      byte_q    <= wr_byte;
      last_q    <= wr_last;
    end
  end

endmodule
